>>> src/source_tokenizer_unit_defines.svh
// Assertion helpers shared by the tokenizer RTL.
// Both macros clock on i_clk and are off while i_rst_n is low.
`ifndef SOURCE_TOKENIZER_UNIT_DEFINES_SVH
`define SOURCE_TOKENIZER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define STU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// Next-cycle implication.
`define STU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

>>> src/stu_pkg.sv
package stu_pkg;

    localparam int POSITION_BITS_DEF   = 32;
    localparam int KEYWORD_MAX_LEN_DEF = 6;

    localparam int OFFSET_W    = 32;
    localparam int VALUE_W     = 64;
    localparam int KIND_W      = 5;
    localparam int KW_LEN_W    = 4;
    localparam int KW_COUNT    = 10;
    localparam int KW_TEXT_W   = 48;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 136;
    localparam int RESULT_Q_DEPTH = 4;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_E_LOW = 8'h65;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_COMMENT,
        MODE_IDENT,
        MODE_INT,
        MODE_FRAC,
        MODE_EXP_START,
        MODE_EXP_DIGITS,
        MODE_MINUS
    } t_scan_mode;

    typedef enum logic [KIND_W-1:0] {
        TK_EOF = 5'd0,
        TK_IDENT,
        TK_KW_FN,
        TK_KW_EXTERN,
        TK_KW_IF,
        TK_KW_THEN,
        TK_KW_ELSE,
        TK_KW_FOR,
        TK_KW_IN,
        TK_KW_AS,
        TK_KW_STRUCT,
        TK_KW_LET,
        TK_NUMBER,
        TK_PLUS,
        TK_MINUS,
        TK_ARROW,
        TK_STAR,
        TK_SLASH,
        TK_LT,
        TK_GT,
        TK_EQ,
        TK_COLON,
        TK_DOT,
        TK_LPAREN,
        TK_RPAREN,
        TK_LBRACE,
        TK_RBRACE,
        TK_COMMA,
        TK_SEMI,
        TK_ERROR
    } t_tok_kind;

    // keyword text right-aligned, first character in the highest used byte
    localparam logic [KW_TEXT_W-1:0] KW_TEXT [KW_COUNT] = '{
        "fn", "extern", "if", "then", "else", "for", "in", "as", "struct", "let"
    };
    localparam logic [KW_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
        4'd2, 4'd6, 4'd2, 4'd4, 4'd4, 4'd3, 4'd2, 4'd2, 4'd6, 4'd3
    };

    typedef struct packed {
        t_tok_kind            kind;
        logic [OFFSET_W-1:0]  start_offset;
        logic [OFFSET_W-1:0]  end_offset;
        logic                 is_float;
        logic [VALUE_W-1:0]   int_value;
        logic                 int_overflow;
        logic                 last;
    } t_token;

    // up to two tokens from one input request, slot a first
    typedef struct packed {
        logic   a_valid;
        t_token a;
        logic   b_valid;
        t_token b;
    } t_scan_res;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_ident_char(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == CH_UNDER;
    endfunction

    function automatic t_tok_kind op_kind(input logic [7:0] c);
        t_tok_kind k;
        unique case (c)
            8'h2B:   k = TK_PLUS;
            8'h2A:   k = TK_STAR;
            8'h2F:   k = TK_SLASH;
            8'h3C:   k = TK_LT;
            8'h3E:   k = TK_GT;
            8'h3D:   k = TK_EQ;
            8'h3A:   k = TK_COLON;
            8'h2E:   k = TK_DOT;
            8'h28:   k = TK_LPAREN;
            8'h29:   k = TK_RPAREN;
            8'h7B:   k = TK_LBRACE;
            8'h7D:   k = TK_RBRACE;
            8'h2C:   k = TK_COMMA;
            8'h3B:   k = TK_SEMI;
            default: k = TK_ERROR;
        endcase
        return k;
    endfunction

    function automatic t_tok_kind keyword_kind(input logic [KW_TEXT_W-1:0] text,
                                               input logic [KW_LEN_W-1:0] len);
        t_tok_kind k;
        k = TK_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (len == KW_LEN[i] && text == KW_TEXT[i]) begin
                k = t_tok_kind'(KIND_W'(int'(TK_KW_FN) + i));
            end
        end
        return k;
    endfunction

    function automatic t_token make_token(input t_tok_kind k,
                                          input logic [OFFSET_W-1:0] s,
                                          input logic [OFFSET_W-1:0] e,
                                          input logic fl,
                                          input logic [VALUE_W-1:0] v,
                                          input logic ov);
        t_token t;
        t.kind         = k;
        t.start_offset = s;
        t.end_offset   = e;
        t.is_float     = fl;
        t.int_value    = v;
        t.int_overflow = ov;
        t.last         = 1'b0;
        return t;
    endfunction

endpackage

>>> src/stu_scanner.sv
`include "source_tokenizer_unit_defines.svh"

module stu_scanner #(
    parameter int POSITION_BITS   = stu_pkg::POSITION_BITS_DEF,
    parameter int KEYWORD_MAX_LEN = stu_pkg::KEYWORD_MAX_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic               i_end,
    input  logic [7:0]         i_byte,
    output stu_pkg::t_scan_res o_res
);

    localparam int POS_W    = POSITION_BITS;
    localparam int PREFIX_W = 8 * KEYWORD_MAX_LEN;
    localparam int LEN_W    = $clog2(KEYWORD_MAX_LEN + 2);
    localparam int VW       = stu_pkg::VALUE_W;

    stu_pkg::t_scan_mode  r_mode, n_mode;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic [POS_W-1:0]     r_start, n_start;
    logic [PREFIX_W-1:0]  r_prefix, n_prefix;
    logic [LEN_W-1:0]     r_len, n_len;
    logic [VW-1:0]        r_acc, n_acc;
    logic                 r_ovf, n_ovf;

    logic [POS_W-1:0]     w_pos_inc;
    logic [3:0]           w_digit;
    logic [VW+3:0]        w_acc_sum;
    logic                 w_acc_ovf;
    logic                 w_fl_v;
    stu_pkg::t_token      w_fl_tok;
    logic                 w_consumed;
    logic                 w_a_v, w_b_v;
    stu_pkg::t_token      w_a, w_b;

    assign w_pos_inc = r_pos + POS_W'(1);
    assign w_digit   = i_byte[3:0];
    // acc * 10 + digit, four guard bits catch the carry out
    assign w_acc_sum = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + (VW+4)'(w_digit);
    assign w_acc_ovf = |w_acc_sum[VW+3:VW];

    // token that closes when the current one is cut off
    always_comb begin
        w_fl_v   = 1'b1;
        w_fl_tok = stu_pkg::make_token(stu_pkg::TK_NUMBER, 32'(r_start), 32'(r_pos),
                                       1'b0, '0, 1'b0);
        unique case (r_mode)
            stu_pkg::MODE_IDENT: begin
                w_fl_tok.kind = stu_pkg::keyword_kind(r_prefix[stu_pkg::KW_TEXT_W-1:0],
                                                      stu_pkg::KW_LEN_W'(r_len));
            end
            stu_pkg::MODE_INT: begin
                w_fl_tok.int_value    = r_acc;
                w_fl_tok.int_overflow = r_ovf;
            end
            stu_pkg::MODE_FRAC, stu_pkg::MODE_EXP_START, stu_pkg::MODE_EXP_DIGITS: begin
                w_fl_tok.is_float = 1'b1;
            end
            stu_pkg::MODE_MINUS: begin
                w_fl_tok.kind       = stu_pkg::TK_MINUS;
                w_fl_tok.end_offset = 32'(r_start + POS_W'(1));
            end
            default: begin
                w_fl_v = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_mode     = r_mode;
        n_pos      = r_pos;
        n_start    = r_start;
        n_prefix   = r_prefix;
        n_len      = r_len;
        n_acc      = r_acc;
        n_ovf      = r_ovf;
        w_consumed = 1'b0;
        w_a_v      = 1'b0;
        w_a        = w_fl_tok;
        w_b_v      = 1'b0;
        w_b        = stu_pkg::make_token(stu_pkg::op_kind(i_byte), 32'(r_pos),
                                         32'(w_pos_inc), 1'b0, '0, 1'b0);
        if (i_end) begin
            w_a_v  = w_fl_v;
            w_b_v  = 1'b1;
            w_b    = stu_pkg::make_token(stu_pkg::TK_EOF, 32'(r_pos), 32'(r_pos),
                                         1'b0, '0, 1'b0);
            n_mode = stu_pkg::MODE_IDLE;
        end else begin
            n_pos = w_pos_inc;
            unique case (r_mode)
                stu_pkg::MODE_COMMENT: begin
                    w_consumed = 1'b1;
                    if (i_byte == stu_pkg::CH_LF) begin
                        n_mode = stu_pkg::MODE_IDLE;
                    end
                end
                stu_pkg::MODE_IDENT: begin
                    if (stu_pkg::is_ident_char(i_byte)) begin
                        w_consumed = 1'b1;
                        if (r_len < LEN_W'(KEYWORD_MAX_LEN)) begin
                            n_prefix = {r_prefix[PREFIX_W-9:0], i_byte};
                        end
                        if (r_len <= LEN_W'(KEYWORD_MAX_LEN)) begin
                            n_len = r_len + LEN_W'(1);
                        end
                    end
                end
                stu_pkg::MODE_INT: begin
                    if (stu_pkg::is_digit(i_byte)) begin
                        w_consumed = 1'b1;
                        if (w_acc_ovf) begin
                            n_acc = '1;
                            n_ovf = 1'b1;
                        end else begin
                            n_acc = w_acc_sum[VW-1:0];
                        end
                    end else if (i_byte == stu_pkg::CH_DOT) begin
                        w_consumed = 1'b1;
                        n_mode     = stu_pkg::MODE_FRAC;
                    end else if (i_byte == stu_pkg::CH_E_LOW || i_byte == stu_pkg::CH_E_UP) begin
                        w_consumed = 1'b1;
                        n_mode     = stu_pkg::MODE_EXP_START;
                    end
                end
                stu_pkg::MODE_FRAC: begin
                    if (stu_pkg::is_digit(i_byte)) begin
                        w_consumed = 1'b1;
                    end else if (i_byte == stu_pkg::CH_E_LOW || i_byte == stu_pkg::CH_E_UP) begin
                        w_consumed = 1'b1;
                        n_mode     = stu_pkg::MODE_EXP_START;
                    end
                end
                stu_pkg::MODE_EXP_START: begin
                    if (stu_pkg::is_digit(i_byte) || i_byte == stu_pkg::CH_PLUS
                            || i_byte == stu_pkg::CH_MINUS) begin
                        w_consumed = 1'b1;
                        n_mode     = stu_pkg::MODE_EXP_DIGITS;
                    end
                end
                stu_pkg::MODE_EXP_DIGITS: begin
                    w_consumed = stu_pkg::is_digit(i_byte);
                end
                stu_pkg::MODE_MINUS: begin
                    if (i_byte == stu_pkg::CH_GT) begin
                        w_consumed = 1'b1;
                        w_a_v      = 1'b1;
                        w_a        = stu_pkg::make_token(stu_pkg::TK_ARROW, 32'(r_start),
                                                         32'(w_pos_inc), 1'b0, '0, 1'b0);
                        n_mode     = stu_pkg::MODE_IDLE;
                    end
                end
                default: begin
                    w_consumed = 1'b0;
                end
            endcase

            // byte not taken by the open token: close it, rescan from idle
            if (!w_consumed) begin
                w_a_v  = w_fl_v;
                w_a    = w_fl_tok;
                n_mode = stu_pkg::MODE_IDLE;
                priority if (stu_pkg::is_space(i_byte)) begin
                    n_mode = stu_pkg::MODE_IDLE;
                end else if (i_byte == stu_pkg::CH_HASH) begin
                    n_mode = stu_pkg::MODE_COMMENT;
                end else if (stu_pkg::is_alpha(i_byte) || i_byte == stu_pkg::CH_UNDER) begin
                    n_mode   = stu_pkg::MODE_IDENT;
                    n_start  = r_pos;
                    n_prefix = PREFIX_W'(i_byte);
                    n_len    = LEN_W'(1);
                end else if (stu_pkg::is_digit(i_byte)) begin
                    n_mode  = stu_pkg::MODE_INT;
                    n_start = r_pos;
                    n_acc   = VW'(w_digit);
                    n_ovf   = 1'b0;
                end else if (i_byte == stu_pkg::CH_MINUS) begin
                    n_mode  = stu_pkg::MODE_MINUS;
                    n_start = r_pos;
                end else begin
                    w_b_v = 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_res.a_valid = w_a_v;
        o_res.a       = w_a;
        o_res.a.last  = !w_b_v;
        o_res.b_valid = w_b_v;
        o_res.b       = w_b;
        o_res.b.last  = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= stu_pkg::MODE_IDLE;
            r_pos    <= '0;
            r_start  <= '0;
            r_prefix <= '0;
            r_len    <= '0;
            r_acc    <= '0;
            r_ovf    <= 1'b0;
        end else if (i_take) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_start  <= n_start;
            r_prefix <= n_prefix;
            r_len    <= n_len;
            r_acc    <= n_acc;
            r_ovf    <= n_ovf;
        end
    end

    `STU_ASSERT_NOW(a_end_gives_eof, i_take && i_end, o_res.b_valid && o_res.b.kind == stu_pkg::TK_EOF)
    `STU_ASSERT_NEXT(a_end_to_idle, i_rst_n && i_take && i_end, r_mode == stu_pkg::MODE_IDLE)
    `STU_ASSERT_NEXT(a_pos_step, i_rst_n && i_take && !i_end, r_pos == $past(r_pos) + POS_W'(1))

endmodule

>>> src/stu_result_q.sv
`include "source_tokenizer_unit_defines.svh"

module stu_result_q (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  stu_pkg::t_scan_res i_res,
    output logic               o_room,
    output logic               o_valid,
    output stu_pkg::t_token    o_token,
    input  logic               i_ready
);

    localparam int DEPTH = stu_pkg::RESULT_Q_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    stu_pkg::t_token   r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_count;

    logic              w_a, w_b, w_pop;
    logic [PTR_W-1:0]  w_wr1;

    assign w_a     = i_push && i_res.a_valid;
    assign w_b     = i_push && i_res.b_valid;
    assign w_wr1   = r_wr + PTR_W'(w_a);
    assign o_valid = r_count != '0;
    assign o_token = r_mem[r_rd];
    assign w_pop   = o_valid && i_ready;
    // room for a full two-token request
    assign o_room  = r_count <= CNT_W'(DEPTH - 2);

    always_ff @(posedge i_clk) begin
        if (w_a) begin
            r_mem[r_wr] <= i_res.a;
        end
        if (w_b) begin
            r_mem[w_wr1] <= i_res.b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= w_wr1 + PTR_W'(w_b);
            r_rd    <= r_rd + PTR_W'(w_pop);
            r_count <= r_count + CNT_W'(w_a) + CNT_W'(w_b) - CNT_W'(w_pop);
        end
    end

    `STU_ASSERT_NOW(a_q_bound, 1'b1, r_count <= CNT_W'(DEPTH))
    `STU_ASSERT_NOW(a_q_push_room, i_push, r_count <= CNT_W'(DEPTH - 2))

endmodule

>>> src/source_tokenizer_unit.sv
// Channel  Dir  Fields (tdata / tuser / tlast)
// -------  ---  ---------------------------------------------------------------
// s_axis   in   tdata: byte_value; tuser: kind (1 = end of input)
// m_axis   out  tdata: token_kind, start_offset, end_offset, is_float,
//               int_value, int_overflow; tlast: last token of a request
//
// One input request is taken per cycle; it is scanned in the same cycle and its
// tokens (zero, one or two) land in a 4-entry result queue.
// Tokens leave one per cycle while m_axis_tready is high, so requests that make
// two tokens (a token cut off by an operator or bad byte, or an open token
// flushed at end of input) pace intake at the output port's one token per cycle.
// s_axis_tready is high while the queue has room for two tokens; an m_axis stall
// only stops intake once the queue holds more than two tokens.
// Synchronous active-low reset returns the scanner to idle at offset zero and
// empties the queue; no clearing pass is needed.
module source_tokenizer_unit #(
    parameter int POSITION_BITS   = stu_pkg::POSITION_BITS_DEF,
    parameter int KEYWORD_MAX_LEN = stu_pkg::KEYWORD_MAX_LEN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input requests
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [stu_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] byte_value
    input  logic [0:0]                      s_axis_tuser,  // [0] kind
    // tokens
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [4:0] token_kind, [36:5] start_offset, [68:37] end_offset, [69] is_float,
    // [133:70] int_value, [134] int_overflow, [135] zero
    output logic [stu_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast
);

    logic               w_take;
    logic               w_room;
    stu_pkg::t_scan_res w_res;
    stu_pkg::t_token    w_tok;

    // request accepted whenever the queue can hold its worst-case two tokens
    assign s_axis_tready = w_room;
    assign w_take        = s_axis_tvalid && w_room;

    stu_scanner #(
        .POSITION_BITS  (POSITION_BITS),
        .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
    ) u_scanner (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_take (w_take),
        .i_end  (s_axis_tuser[0]),
        .i_byte (s_axis_tdata),
        .o_res  (w_res)
    );

    stu_result_q u_result_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_take),
        .i_res  (w_res),
        .o_room (w_room),
        .o_valid(m_axis_tvalid),
        .o_token(w_tok),
        .i_ready(m_axis_tready)
    );

    // pack the token fields low to high, pad to a whole byte
    assign m_axis_tdata = {1'b0, w_tok.int_overflow, w_tok.int_value, w_tok.is_float,
                           w_tok.end_offset, w_tok.start_offset, w_tok.kind};
    assign m_axis_tlast = w_tok.last;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import stu_pkg::*;

    // Expected-token tracker: scans each accepted request the same way the block
    // does and queues the tokens that request should produce.
    class token_scoreboard;
        t_scan_mode  mode;
        logic [31:0] pos;
        logic [31:0] tok_start;
        string       id_text;     // first KEYWORD_MAX_LEN_DEF identifier chars
        int          id_len;      // saturates one past the keyword limit
        logic [63:0] acc;
        bit          acc_sat;
        t_token      step_toks[$];
        t_token      expected_toks[$];
        int          errors;
        int          requests_seen;

        function new();
            mode          = MODE_IDLE;
            pos           = '0;
            tok_start     = '0;
            id_text       = "";
            id_len        = 0;
            acc           = '0;
            acc_sat       = 1'b0;
            errors        = 0;
            requests_seen = 0;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_numeral(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        // space, tab, LF, VT, FF, CR
        function bit is_blank(logic [7:0] c);
            return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
        endfunction

        function t_tok_kind punct_kind(logic [7:0] c);
            case (c)
                "+":     return TK_PLUS;
                "*":     return TK_STAR;
                "/":     return TK_SLASH;
                "<":     return TK_LT;
                ">":     return TK_GT;
                "=":     return TK_EQ;
                ":":     return TK_COLON;
                ".":     return TK_DOT;
                "(":     return TK_LPAREN;
                ")":     return TK_RPAREN;
                "{":     return TK_LBRACE;
                "}":     return TK_RBRACE;
                ",":     return TK_COMMA;
                ";":     return TK_SEMI;
                default: return TK_ERROR;
            endcase
        endfunction

        function t_tok_kind word_kind();
            if (id_len > KEYWORD_MAX_LEN_DEF) return TK_IDENT;
            case (id_text)
                "fn":     return TK_KW_FN;
                "extern": return TK_KW_EXTERN;
                "if":     return TK_KW_IF;
                "then":   return TK_KW_THEN;
                "else":   return TK_KW_ELSE;
                "for":    return TK_KW_FOR;
                "in":     return TK_KW_IN;
                "as":     return TK_KW_AS;
                "struct": return TK_KW_STRUCT;
                "let":    return TK_KW_LET;
                default:  return TK_IDENT;
            endcase
        endfunction

        function void add_token(t_tok_kind k, logic [31:0] s, logic [31:0] e, bit fl,
                                logic [63:0] v, bit ov);
            t_token t;
            t              = '0;
            t.kind         = k;
            t.start_offset = s;
            t.end_offset   = e;
            t.is_float     = fl;
            t.int_value    = v;
            t.int_overflow = ov;
            step_toks.push_back(t);
        endfunction

        // emit whatever token is open, ending at the current position
        function void close_token();
            case (mode)
                MODE_IDENT: add_token(word_kind(), tok_start, pos, 1'b0, '0, 1'b0);
                MODE_INT:   add_token(TK_NUMBER, tok_start, pos, 1'b0, acc, acc_sat);
                MODE_FRAC, MODE_EXP_START, MODE_EXP_DIGITS:
                    add_token(TK_NUMBER, tok_start, pos, 1'b1, '0, 1'b0);
                MODE_MINUS: add_token(TK_MINUS, tok_start, tok_start + 32'd1, 1'b0, '0, 1'b0);
                default: ;
            endcase
            mode = MODE_IDLE;
        endfunction

        function void open_token(logic [7:0] c);
            if (is_blank(c)) return;
            if (c == "#") begin
                mode = MODE_COMMENT;
            end else if (is_letter(c) || c == "_") begin
                mode      = MODE_IDENT;
                tok_start = pos;
                id_text   = "";
                id_text   = {id_text, string'(c)};
                id_len    = 1;
            end else if (is_numeral(c)) begin
                mode      = MODE_INT;
                tok_start = pos;
                acc       = 64'(c) - 64'd48;
                acc_sat   = 1'b0;
            end else if (c == "-") begin
                mode      = MODE_MINUS;
                tok_start = pos;
            end else begin
                add_token(punct_kind(c), pos, pos + 32'd1, 1'b0, '0, 1'b0);
            end
        endfunction

        // 1 when the byte is taken into the open token
        function bit continue_token(logic [7:0] c);
            logic [67:0] wide;
            case (mode)
                MODE_COMMENT: begin
                    if (c == 8'h0A) mode = MODE_IDLE;
                    return 1'b1;
                end
                MODE_IDENT: begin
                    if (!(is_letter(c) || is_numeral(c) || c == "_")) return 1'b0;
                    if (id_len < KEYWORD_MAX_LEN_DEF) id_text = {id_text, string'(c)};
                    if (id_len <= KEYWORD_MAX_LEN_DEF) id_len++;
                    return 1'b1;
                end
                MODE_INT: begin
                    if (is_numeral(c)) begin
                        wide = {4'b0, acc} * 68'd10 + 68'(c) - 68'd48;
                        if (wide[67:64] != 4'b0) begin
                            acc     = '1;
                            acc_sat = 1'b1;
                        end else begin
                            acc = wide[63:0];
                        end
                        return 1'b1;
                    end
                    if (c == ".") begin
                        mode = MODE_FRAC;
                        return 1'b1;
                    end
                    if (c == "e" || c == "E") begin
                        mode = MODE_EXP_START;
                        return 1'b1;
                    end
                    return 1'b0;
                end
                MODE_FRAC: begin
                    if (is_numeral(c)) return 1'b1;
                    if (c == "e" || c == "E") begin
                        mode = MODE_EXP_START;
                        return 1'b1;
                    end
                    return 1'b0;
                end
                MODE_EXP_START: begin
                    if (is_numeral(c) || c == "+" || c == "-") begin
                        mode = MODE_EXP_DIGITS;
                        return 1'b1;
                    end
                    return 1'b0;
                end
                MODE_EXP_DIGITS: return is_numeral(c);
                MODE_MINUS: begin
                    if (c == ">") begin
                        add_token(TK_ARROW, tok_start, pos + 32'd1, 1'b0, '0, 1'b0);
                        mode = MODE_IDLE;
                        return 1'b1;
                    end
                    return 1'b0;
                end
                default: return 1'b0;
            endcase
        endfunction

        function void note_request(bit end_mark, logic [7:0] c);
            step_toks.delete();
            requests_seen++;
            if (end_mark) begin
                close_token();
                add_token(TK_EOF, pos, pos, 1'b0, '0, 1'b0);
            end else begin
                if (mode == MODE_IDLE) begin
                    open_token(c);
                end else if (!continue_token(c)) begin
                    close_token();
                    open_token(c);
                end
                pos = pos + 32'd1;
            end
            if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
            foreach (step_toks[i]) expected_toks.push_back(step_toks[i]);
        endfunction

        function int pending();
            return expected_toks.size();
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_token(logic [OUT_TDATA_W-1:0] d, logic tl);
            t_token want;
            if (expected_toks.size() == 0) begin
                $error("token with none expected: kind %0d start %0d", d[4:0], d[36:5]);
                errors++;
                return;
            end
            want = expected_toks.pop_front();
            compare_field("token_kind",   64'(want.kind),         64'(d[4:0]));
            compare_field("start_offset", 64'(want.start_offset), 64'(d[36:5]));
            compare_field("end_offset",   64'(want.end_offset),   64'(d[68:37]));
            compare_field("is_float",     64'(want.is_float),     64'(d[69]));
            compare_field("int_value",    want.int_value,         d[133:70]);
            compare_field("int_overflow", 64'(want.int_overflow), 64'(d[134]));
            compare_field("last",         64'(want.last),         64'(tl));
        endfunction
    endclass

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 950;
    localparam int LONG_HOLD     = 500;   // receiver hold-off, in cycles
    localparam int HOLD_AT_REQ   = 400;   // request count that triggers it
    localparam int DRAIN_AT_ITEM = 500;   // mid-run point where the sender drains

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [7:0] byte_value
    logic [0:0]             s_axis_tuser;   // [0] kind (1 = end of input)
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [4:0] token_kind, [36:5] start_offset, [68:37] end_offset, [69] is_float,
    // [133:70] int_value, [134] int_overflow, [135] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    token_scoreboard sb;
    int              cycles;
    int              burst_left;     // requests left in the current sender burst
    int              items_counted;  // requests accepted so far
    bit              hold_done;

    source_tokenizer_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Token monitor. Runs in the active region at the rising edge, so it sees the
    // values the block presented during the cycle that just ended.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_token(m_axis_tdata, m_axis_tlast);
        end
    end

    // Receiver: ready pattern changes style every so often (always ready, coin
    // flip, mostly stalled, periodic). Once, after enough requests, it holds off
    // for a long stretch so the result queue fills and intake backs up.
    initial begin : receiver
        int style;
        int style_left;
        int hold_left;
        style      = 0;
        style_left = 0;
        hold_left  = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!hold_done && sb.requests_seen >= HOLD_AT_REQ) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready = 1'b0;
            end else begin
                if (style_left == 0) begin
                    style      = $urandom_range(0, 3);
                    style_left = $urandom_range(16, 96);
                end
                style_left--;
                case (style)
                    0:       m_axis_tready = 1'b1;
                    1:       m_axis_tready = $urandom_range(0, 1);
                    2:       m_axis_tready = ($urandom_range(0, 3) == 0);
                    default: m_axis_tready = (cycles % 3 != 0);
                endcase
            end
        end
    end

    // Offer one request and wait for its handshake. Bursts of random length are
    // separated by random gaps; valid stays high across back-to-back requests.
    task automatic send_item(input bit end_mark, input logic [7:0] c);
        int gap;
        @(negedge i_clk);
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25) : $urandom_range(0, 5);
            if (gap > 0) begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 24);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = c;
        s_axis_tuser  = end_mark;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(end_mark, c);
        burst_left--;
        items_counted++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
    endtask

    // Sender pause: drop valid and wait until every expected token has come.
    task automatic drain_tokens();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic send_digits(input int n);
        for (int i = 0; i < n; i++) send_item(1'b0, 8'(48 + $urandom_range(0, 9)));
    endtask

    // One random lexeme, mostly well formed, some noise and broken forms.
    task automatic send_lexeme();
        string keywords [10] = '{"fn", "extern", "if", "then", "else", "for", "in", "as",
                                 "struct", "let"};
        string near_words [14] = '{"fnx", "extern_", "iff", "the", "elses", "fo", "i", "a",
                                   "structs", "le", "Fn", "LET", "externs", "struct9"};
        string id_head = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
        string id_tail = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        string puncts  = "+*/<>=:.(){},;";
        string oddities = "!\"$%&'?@[\\]^|~";
        string blanks  = " \t\n\v\f\r";
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            send_text(keywords[$urandom_range(0, 9)]);
        end else if (pick < 17) begin
            send_text(near_words[$urandom_range(0, 13)]);
        end else if (pick < 30) begin
            send_item(1'b0, id_head[$urandom_range(0, id_head.len() - 1)]);
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
            for (int i = 0; i < n; i++) send_item(1'b0, id_tail[$urandom_range(0, id_tail.len() - 1)]);
        end else if (pick < 45) begin
            // number: integer part, optional fraction, optional exponent
            case ($urandom_range(0, 19))
                0:       send_text("18446744073709551615");   // largest value, no overflow
                1:       send_text("18446744073709551616");   // one past, saturates
                2:       send_digits($urandom_range(19, 25));
                default: send_digits($urandom_range(1, 6));
            endcase
            if ($urandom_range(0, 3) == 0) begin
                send_item(1'b0, ".");
                send_digits($urandom_range(0, 3));
            end
            if ($urandom_range(0, 4) == 0) begin
                send_item(1'b0, $urandom_range(0, 1) ? "e" : "E");
                case ($urandom_range(0, 2))
                    0:       send_item(1'b0, "+");
                    1:       send_item(1'b0, "-");
                    default: ;
                endcase
                send_digits($urandom_range(0, 3));
            end
        end else if (pick < 59) begin
            send_item(1'b0, puncts[$urandom_range(0, puncts.len() - 1)]);
        end else if (pick < 66) begin
            case ($urandom_range(0, 3))
                0:       send_text("->");
                1:       send_text("-");
                2:       send_text("--");
                default: send_text("-=");
            endcase
        end else if (pick < 73) begin
            // comment with arbitrary content, usually closed by a line feed
            send_item(1'b0, "#");
            n = $urandom_range(0, 12);
            for (int i = 0; i < n; i++) send_item(1'b0, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 6) != 0) send_item(1'b0, 8'h0A);
        end else if (pick < 82) begin
            send_item(1'b0, 8'($urandom_range(0, 255)));
        end else if (pick < 88) begin
            if ($urandom_range(0, 1))
                send_item(1'b0, oddities[$urandom_range(0, oddities.len() - 1)]);
            else
                send_item(1'b0, 8'($urandom_range(128, 255)));
        end else if (pick < 97) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) send_item(1'b0, blanks[$urandom_range(0, 5)]);
        end else begin
            send_item(1'b1, 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : stimulus
        bit drained_mid;
        sb            = new();
        cycles        = 0;
        burst_left    = 0;
        items_counted = 0;
        hold_done     = 1'b0;
        drained_mid   = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: keyword cut by an operator, arrow, minus followed by a digit,
        // float with a signed exponent cut by a high unknown byte, a comment
        // holding a NUL, identifier flushed at end of input, end of input while
        // idle, and a bare exponent flushed at end of input.
        send_text("struct(->-7.5e-");
        send_item(1'b0, 8'hFF);
        send_item(1'b0, "#");
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'h0A);
        send_text("_a");
        send_item(1'b1, 8'h00);
        send_item(1'b1, 8'hAA);
        send_text("9E");
        send_item(1'b1, 8'h55);
        drain_tokens();

        items_counted = 0;
        while (items_counted < RANDOM_ITEMS) begin
            send_lexeme();
            // separator half the time, so tokens also abut each other
            if ($urandom_range(0, 1)) send_item(1'b0, 8'h20);
            if (!drained_mid && items_counted >= DRAIN_AT_ITEM) begin
                drained_mid = 1'b1;
                drain_tokens();
            end
        end
        send_item(1'b1, 8'h00);

        drain_tokens();
        repeat (16) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
